// File: src/order_lifecycle_tracker_unit_macros.svh
// Assertion macros shared by the order lifecycle tracker checker.
`ifndef ORDER_LIFECYCLE_TRACKER_UNIT_MACROS_SVH
`define ORDER_LIFECYCLE_TRACKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/olt_pkg.sv
// Types, codes, stream layout and transition rules of the order lifecycle tracker.
`timescale 1ns / 1ps
package olt_pkg;

  localparam int LC_W        = 4;
  localparam int SLOT_W      = 6;
  localparam int VOL_PORT_W  = 32;
  localparam int RC_W        = 2;
  localparam int RS_W        = 3;
  localparam int REQ_W       = 3;
  localparam int OUTCOME_W   = 2;

  // Input tdata layout.
  localparam int IN_SLOT_LSB   = 0;
  localparam int IN_QTY_LSB    = IN_SLOT_LSB + SLOT_W;
  localparam int IN_RC_LSB     = IN_QTY_LSB + VOL_PORT_W;
  localparam int IN_RS_LSB     = IN_RC_LSB + RC_W;
  localparam int IN_RTR_LSB    = IN_RS_LSB + RS_W;
  localparam int IN_RLF_LSB    = IN_RTR_LSB + VOL_PORT_W;
  localparam int IN_USED_W     = IN_RLF_LSB + VOL_PORT_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout.
  localparam int OUT_OUTCOME_LSB = 0;
  localparam int OUT_LC_LSB      = OUT_OUTCOME_LSB + OUTCOME_W;
  localparam int OUT_LEFT_LSB    = OUT_LC_LSB + LC_W;
  localparam int OUT_TRADED_LSB  = OUT_LEFT_LSB + VOL_PORT_W;
  localparam int OUT_USED_W      = OUT_TRADED_LSB + VOL_PORT_W;
  localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [LC_W-1:0] {
    LC_PREPARED       = 4'd0,
    LC_QUEUED         = 4'd1,
    LC_SEND_PENDING   = 4'd2,
    LC_SEND_UNKNOWN   = 4'd3,
    LC_WORKING        = 4'd4,
    LC_PART           = 4'd5,
    LC_CANCEL_PENDING = 4'd6,
    LC_FILLED         = 4'd7,
    LC_CANCELED       = 4'd8,
    LC_REJECTED       = 4'd9
  } lc_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE        = 3'd0,
    REQ_CANCEL        = 3'd1,
    REQ_MARK_QUEUED   = 3'd2,
    REQ_MARK_SEND     = 3'd3,
    REQ_SEND_RESULT   = 3'd4,
    REQ_CANCEL_RESULT = 3'd5,
    REQ_ORDER_REPORT  = 3'd6,
    REQ_TRADE_REPORT  = 3'd7
  } req_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_SUCCESS   = 2'd0,
    OUT_NOT_FOUND = 2'd1,
    OUT_INVALID   = 2'd2
  } outcome_t;

  localparam logic [OUTCOME_W-1:0] OUT_RESERVED = 2'd3;

  localparam logic [RC_W-1:0] RC_SUCCESS = 2'd0;
  localparam logic [RC_W-1:0] RC_TIMEOUT = 2'd1;

  localparam logic [RS_W-1:0] RS_FILLED      = 3'd1;
  localparam logic [RS_W-1:0] RS_PART        = 3'd2;
  localparam logic [RS_W-1:0] RS_PART_NOQ    = 3'd3;
  localparam logic [RS_W-1:0] RS_CANCELED    = 3'd4;
  localparam logic [RS_W-1:0] RS_REJECTED    = 3'd5;
  localparam logic [RS_W-1:0] RS_UNKNOWN     = 3'd6;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } olt_state_t;

  function automatic logic move_ok(input lc_t from_lc, input lc_t to_lc);
    logic [15:0] mask;
    mask = '0;
    unique case (from_lc)
      LC_PREPARED: begin
        mask[LC_QUEUED] = 1'b1;
        mask[LC_REJECTED] = 1'b1;
        mask[LC_SEND_UNKNOWN] = 1'b1;
        mask[LC_CANCEL_PENDING] = 1'b1;
      end
      LC_QUEUED: begin
        mask[LC_SEND_PENDING] = 1'b1;
        mask[LC_REJECTED] = 1'b1;
        mask[LC_CANCEL_PENDING] = 1'b1;
      end
      LC_SEND_PENDING: begin
        mask[LC_WORKING] = 1'b1;
        mask[LC_REJECTED] = 1'b1;
        mask[LC_SEND_UNKNOWN] = 1'b1;
        mask[LC_PART] = 1'b1;
        mask[LC_FILLED] = 1'b1;
      end
      LC_SEND_UNKNOWN: begin
        mask[LC_WORKING] = 1'b1;
        mask[LC_REJECTED] = 1'b1;
        mask[LC_PART] = 1'b1;
        mask[LC_FILLED] = 1'b1;
        mask[LC_CANCELED] = 1'b1;
      end
      LC_WORKING: begin
        mask[LC_PART] = 1'b1;
        mask[LC_FILLED] = 1'b1;
        mask[LC_CANCEL_PENDING] = 1'b1;
        mask[LC_CANCELED] = 1'b1;
        mask[LC_REJECTED] = 1'b1;
      end
      LC_PART: begin
        mask[LC_FILLED] = 1'b1;
        mask[LC_CANCEL_PENDING] = 1'b1;
        mask[LC_CANCELED] = 1'b1;
      end
      LC_CANCEL_PENDING: begin
        mask[LC_CANCELED] = 1'b1;
        mask[LC_WORKING] = 1'b1;
        mask[LC_PART] = 1'b1;
        mask[LC_FILLED] = 1'b1;
        mask[LC_REJECTED] = 1'b1;
      end
      default: mask = '0;
    endcase
    return (from_lc == to_lc) || mask[to_lc];
  endfunction

  function automatic lc_t status_target(input logic [RS_W-1:0] rs, input lc_t cur);
    lc_t tgt;
    priority case (rs)
      RS_FILLED:   tgt = LC_FILLED;
      RS_PART:     tgt = LC_PART;
      RS_PART_NOQ: tgt = LC_PART;
      RS_CANCELED: tgt = LC_CANCELED;
      RS_REJECTED: tgt = LC_REJECTED;
      RS_UNKNOWN:  tgt = LC_SEND_UNKNOWN;
      default:     tgt = (cur == LC_PREPARED) ? LC_WORKING : cur;
    endcase
    return tgt;
  endfunction

endpackage

// File: src/order_lifecycle_tracker_unit.sv
// Top level of the order lifecycle tracker: slot table memories and request sequencer.
//
// Requests arrive on the in_ stream: in_tuser carries the request kind and in_tdata
// the slot index, volumes and broker codes. Each accepted item yields exactly one
// result item on the out_ stream with the outcome, the slot lifecycle and its
// traded and left volumes after the request.
// Each item is handled in turn: the accepting edge issues the read of the slot entry
// and its valid bit, and in the execute state the block checks the move, writes the entry
// back and loads the output register, once that register is free. The next item is
// accepted in the cycle after that at the earliest, so the block takes no new item before
// it is through with the last, set by the single read-modify-write of the entry memory.
// After reset the valid memory is swept clear, one slot a cycle, through all ORDER_SLOTS
// slots, during which no item is accepted.
// When the receiver stalls, the result waits in the output register while one more
// item is accepted and read; its write-back waits until the register frees, so no
// result is lost or reordered.
`timescale 1ns / 1ps
module order_lifecycle_tracker_unit
  import olt_pkg::*;
#(
  parameter int ORDER_SLOTS = 64,
  parameter int VOLUME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // slot, qty, result_code, report_status, report_traded, report_left, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [REQ_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // outcome, lifecycle, left, traded, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W   = $clog2(ORDER_SLOTS);
  localparam int SEL_W   = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int EXT_W   = (VOLUME_BITS > VOL_PORT_W) ? VOLUME_BITS : VOL_PORT_W;
  localparam int ENTRY_W = LC_W + 3 * VOLUME_BITS;
  localparam logic [VOLUME_BITS-1:0] VOL_MAX = '1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_SLOTS - 1);

  olt_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r;

  logic [ENTRY_W-1:0] entry_mem [ORDER_SLOTS];
  logic               valid_mem [ORDER_SLOTS];
  logic [ENTRY_W-1:0] entry_rd_r;
  logic               valid_rd_r;

  logic in_acc, exec_fire;

  logic [SEL_W-1:0] slot_sel;
  logic [IDX_W-1:0] idx_in;
  logic             in_range;
  logic [EXT_W-1:0] qty_ext, rtr_ext, rlf_ext;

  req_t                   req_r;
  logic                   in_range_r;
  logic [IDX_W-1:0]       idx_r;
  logic [VOLUME_BITS-1:0] qty_r, rtr_r, rlf_r;
  logic [RC_W-1:0]        rc_r;
  logic [RS_W-1:0]        rs_r;

  lc_t                    cur_lc, tgt_lc, res_lc;
  logic [VOLUME_BITS-1:0] cur_vol, cur_trd, cur_left;
  logic [VOLUME_BITS-1:0] nv, nt, nl;
  logic [VOLUME_BITS-1:0] res_vol, res_trd, res_left;
  logic [VOLUME_BITS:0]   trade_sum;
  logic [VOLUME_BITS-1:0] trade_trd, trade_left;
  outcome_t               res_outcome;
  logic                   ent_we;
  logic [EXT_W-1:0]       res_left_ext, res_trd_ext;

  logic                   vld_we, vld_wdata;
  logic [IDX_W-1:0]       vld_waddr;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Request unpacking.
  assign slot_sel = SEL_W'(in_tdata[IN_SLOT_LSB +: SLOT_W]);
  assign in_range = (slot_sel < SEL_W'(ORDER_SLOTS));
  assign idx_in   = slot_sel[IDX_W-1:0];
  assign qty_ext  = EXT_W'(in_tdata[IN_QTY_LSB +: VOL_PORT_W]);
  assign rtr_ext  = EXT_W'(in_tdata[IN_RTR_LSB +: VOL_PORT_W]);
  assign rlf_ext  = EXT_W'(in_tdata[IN_RLF_LSB +: VOL_PORT_W]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    exec_fire = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r      <= req_t'(in_tuser);
      in_range_r <= in_range;
      idx_r      <= idx_in;
      qty_r      <= qty_ext[VOLUME_BITS-1:0];
      rtr_r      <= rtr_ext[VOLUME_BITS-1:0];
      rlf_r      <= rlf_ext[VOLUME_BITS-1:0];
      rc_r       <= in_tdata[IN_RC_LSB +: RC_W];
      rs_r       <= in_tdata[IN_RS_LSB +: RS_W];
    end
  end

  // Slot memories.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      entry_rd_r <= entry_mem[idx_in];
    end
    if (ent_we) begin
      entry_mem[idx_r] <= {res_lc, res_vol, res_trd, res_left};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      valid_rd_r <= valid_mem[idx_in];
    end
    if (vld_we) begin
      valid_mem[vld_waddr] <= vld_wdata;
    end
  end

  always_comb begin
    vld_we    = (state_r == ST_CLEAR) ||
                (exec_fire && in_range_r && (req_r == REQ_CREATE));
    vld_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : idx_r;
    vld_wdata = (state_r != ST_CLEAR);
  end

  // Lifecycle move and volume update.
  always_comb begin
    cur_lc   = lc_t'(entry_rd_r[ENTRY_W-1 -: LC_W]);
    cur_vol  = entry_rd_r[3*VOLUME_BITS-1 -: VOLUME_BITS];
    cur_trd  = entry_rd_r[2*VOLUME_BITS-1 -: VOLUME_BITS];
    cur_left = entry_rd_r[VOLUME_BITS-1:0];

    trade_sum  = {1'b0, cur_trd} + {1'b0, qty_r};
    trade_trd  = trade_sum[VOLUME_BITS] ? VOL_MAX : trade_sum[VOLUME_BITS-1:0];
    trade_left = (cur_vol > trade_trd) ? (cur_vol - trade_trd) : '0;

    tgt_lc = cur_lc;
    nv     = cur_vol;
    nt     = cur_trd;
    nl     = cur_left;
    unique case (req_r)
      REQ_CREATE:      tgt_lc = cur_lc;
      REQ_CANCEL:      tgt_lc = LC_CANCEL_PENDING;
      REQ_MARK_QUEUED: tgt_lc = LC_QUEUED;
      REQ_MARK_SEND:   tgt_lc = LC_SEND_PENDING;
      REQ_SEND_RESULT: begin
        if ((cur_lc == LC_SEND_PENDING) || ((cur_lc == LC_QUEUED) && (rc_r != RC_SUCCESS))) begin
          priority if (rc_r == RC_SUCCESS) tgt_lc = LC_WORKING;
          else if (rc_r == RC_TIMEOUT) tgt_lc = LC_SEND_UNKNOWN;
          else tgt_lc = LC_REJECTED;
        end
      end
      REQ_CANCEL_RESULT: begin
        priority if ((rc_r == RC_SUCCESS) || (rc_r == RC_TIMEOUT)) tgt_lc = LC_CANCEL_PENDING;
        else if (cur_trd != '0) tgt_lc = LC_PART;
        else tgt_lc = LC_WORKING;
      end
      REQ_ORDER_REPORT: begin
        if (qty_r != '0) nv = qty_r;
        nt     = rtr_r;
        nl     = rlf_r;
        tgt_lc = status_target(rs_r, cur_lc);
      end
      REQ_TRADE_REPORT: begin
        nt     = trade_trd;
        nl     = trade_left;
        tgt_lc = (trade_left == '0) ? LC_FILLED : LC_PART;
      end
      default: tgt_lc = cur_lc;
    endcase

    ent_we      = 1'b0;
    res_outcome = OUT_SUCCESS;
    res_lc      = cur_lc;
    res_vol     = cur_vol;
    res_trd     = cur_trd;
    res_left    = cur_left;
    priority if (!in_range_r || ((req_r != REQ_CREATE) && !valid_rd_r)) begin
      res_outcome = OUT_NOT_FOUND;
      res_lc      = LC_PREPARED;
      res_vol     = '0;
      res_trd     = '0;
      res_left    = '0;
    end else if (req_r == REQ_CREATE) begin
      ent_we   = exec_fire;
      res_lc   = LC_PREPARED;
      res_vol  = qty_r;
      res_trd  = '0;
      res_left = qty_r;
    end else if (move_ok(cur_lc, tgt_lc)) begin
      ent_we   = exec_fire;
      res_lc   = tgt_lc;
      res_vol  = nv;
      res_trd  = nt;
      res_left = nl;
    end else begin
      res_outcome = OUT_INVALID;
    end

    res_left_ext = EXT_W'(res_left);
    res_trd_ext  = EXT_W'(res_trd);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (exec_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_tdata_r <= {(OUT_TDATA_W - OUT_USED_W)'(0),
                      res_trd_ext[VOL_PORT_W-1:0],
                      res_left_ext[VOL_PORT_W-1:0],
                      res_lc,
                      res_outcome};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: src/olt_checker.sv
// Port-level checker of the order lifecycle tracker and its bind to the top level.
`timescale 1ns / 1ps
`include "order_lifecycle_tracker_unit_macros.svh"
module olt_checker
  import olt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `OLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result item changed")
  `OLT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "item accepted while another is in work")
  `OLT_ASSERT_SAME(a_codes_legal, clk, rst_n, out_tvalid, (out_tdata[OUT_LC_LSB +: LC_W] <= LC_REJECTED) && (out_tdata[OUT_OUTCOME_LSB +: OUTCOME_W] != OUT_RESERVED), "result carries an undefined code")
  `OLT_ASSERT_SAME(a_not_found_zero, clk, rst_n, out_tvalid && (out_tdata[OUT_OUTCOME_LSB +: OUTCOME_W] == OUT_NOT_FOUND), out_tdata[OUT_USED_W-1:OUT_LC_LSB] == '0, "missing slot result is not zero")

endmodule

bind order_lifecycle_tracker_unit olt_checker u_olt_checker (.*);

// File: dv/order_lifecycle_tracker_unit_test.sv
// Self-checking stream testbench for the order lifecycle tracker, with its own order book model.
`timescale 1ns / 1ps
module order_lifecycle_tracker_unit_test;
  import olt_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 250;
  localparam int PHASE_ITEMS   = 400;
  localparam int BOOK_SLOTS    = 64;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct packed {
    req_t            kind;
    logic [5:0]      slot;
    logic [31:0]     qty;
    logic [1:0]      rc;
    logic [2:0]      rs;
    logic [31:0]     rtr;
    logic [31:0]     rlf;
  } order_req_t;

  typedef struct packed {
    outcome_t        outcome;
    lc_t             lc;
    logic [31:0]     left;
    logic [31:0]     traded;
  } order_result_t;

  typedef struct packed {
    order_req_t      req;
    logic            typed;
    order_result_t   want;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  order_lifecycle_tracker_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  bit            book_valid [BOOK_SLOTS];
  lc_t           book_lc [BOOK_SLOTS];
  logic [31:0]   book_volume [BOOK_SLOTS];
  logic [31:0]   book_traded [BOOK_SLOTS];
  logic [31:0]   book_left [BOOK_SLOTS];

  order_result_t pending_replies [$];
  directed_row_t directed_rows [$];
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  bit            hold_pending = 1'b0;
  int            failures = 0;
  int            sent_count = 0;
  int            checked_count = 0;
  int            outcome_count [4];
  bit [15:0]     lc_seen = '0;
  int            cycle_count = 0;
  order_result_t got;
  order_result_t want;

  function automatic bit transition_allowed(input lc_t from_lc, input lc_t to_lc);
    logic [15:0] mask;
    case (from_lc)
      LC_PREPARED: mask = (16'd1 << LC_QUEUED) | (16'd1 << LC_REJECTED) |
        (16'd1 << LC_SEND_UNKNOWN) | (16'd1 << LC_CANCEL_PENDING);
      LC_QUEUED: mask = (16'd1 << LC_SEND_PENDING) | (16'd1 << LC_REJECTED) |
        (16'd1 << LC_CANCEL_PENDING);
      LC_SEND_PENDING: mask = (16'd1 << LC_WORKING) | (16'd1 << LC_REJECTED) |
        (16'd1 << LC_SEND_UNKNOWN) | (16'd1 << LC_PART) | (16'd1 << LC_FILLED);
      LC_SEND_UNKNOWN: mask = (16'd1 << LC_WORKING) | (16'd1 << LC_REJECTED) |
        (16'd1 << LC_PART) | (16'd1 << LC_FILLED) | (16'd1 << LC_CANCELED);
      LC_WORKING: mask = (16'd1 << LC_PART) | (16'd1 << LC_FILLED) |
        (16'd1 << LC_CANCEL_PENDING) | (16'd1 << LC_CANCELED) | (16'd1 << LC_REJECTED);
      LC_PART: mask = (16'd1 << LC_FILLED) | (16'd1 << LC_CANCEL_PENDING) |
        (16'd1 << LC_CANCELED);
      LC_CANCEL_PENDING: mask = (16'd1 << LC_CANCELED) | (16'd1 << LC_WORKING) |
        (16'd1 << LC_PART) | (16'd1 << LC_FILLED) | (16'd1 << LC_REJECTED);
      default: mask = '0;
    endcase
    return (from_lc == to_lc) || mask[to_lc];
  endfunction

  function automatic lc_t report_target(input logic [2:0] rs, input lc_t cur);
    case (rs)
      RS_FILLED:   return LC_FILLED;
      RS_PART:     return LC_PART;
      RS_PART_NOQ: return LC_PART;
      RS_CANCELED: return LC_CANCELED;
      RS_REJECTED: return LC_REJECTED;
      RS_UNKNOWN:  return LC_SEND_UNKNOWN;
      default:     return (cur == LC_PREPARED) ? LC_WORKING : cur;
    endcase
  endfunction

  function automatic order_result_t apply_to_order_book(input order_req_t r);
    order_result_t res;
    lc_t           cur;
    lc_t           tgt;
    logic [31:0]   nv;
    logic [31:0]   nt;
    logic [31:0]   nl;
    logic [32:0]   sum;
    res = '0;
    res.outcome = OUT_SUCCESS;
    if (r.kind == REQ_CREATE) begin
      book_valid[r.slot] = 1'b1;
      book_lc[r.slot] = LC_PREPARED;
      book_volume[r.slot] = r.qty;
      book_traded[r.slot] = '0;
      book_left[r.slot] = r.qty;
    end else if (!book_valid[r.slot]) begin
      res.outcome = OUT_NOT_FOUND;
      res.lc = LC_PREPARED;
      return res;
    end else begin
      cur = book_lc[r.slot];
      tgt = cur;
      nv = book_volume[r.slot];
      nt = book_traded[r.slot];
      nl = book_left[r.slot];
      case (r.kind)
        REQ_CANCEL:      tgt = LC_CANCEL_PENDING;
        REQ_MARK_QUEUED: tgt = LC_QUEUED;
        REQ_MARK_SEND:   tgt = LC_SEND_PENDING;
        REQ_SEND_RESULT: begin
          if (cur == LC_SEND_PENDING || (cur == LC_QUEUED && r.rc != RC_SUCCESS)) begin
            if (r.rc == RC_SUCCESS) tgt = LC_WORKING;
            else if (r.rc == RC_TIMEOUT) tgt = LC_SEND_UNKNOWN;
            else tgt = LC_REJECTED;
          end
        end
        REQ_CANCEL_RESULT: begin
          if (r.rc == RC_SUCCESS || r.rc == RC_TIMEOUT) tgt = LC_CANCEL_PENDING;
          else tgt = (nt != 0) ? LC_PART : LC_WORKING;
        end
        REQ_ORDER_REPORT: begin
          if (r.qty != 0) nv = r.qty;
          nt = r.rtr;
          nl = r.rlf;
          tgt = report_target(r.rs, cur);
        end
        default: begin
          sum = {1'b0, nt} + {1'b0, r.qty};
          nt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          nl = (nv > nt) ? nv - nt : 32'd0;
          tgt = (nl == 0) ? LC_FILLED : LC_PART;
        end
      endcase
      if (transition_allowed(cur, tgt)) begin
        book_lc[r.slot] = tgt;
        book_volume[r.slot] = nv;
        book_traded[r.slot] = nt;
        book_left[r.slot] = nl;
      end else begin
        res.outcome = OUT_INVALID;
      end
    end
    res.lc = book_lc[r.slot];
    res.left = book_left[r.slot];
    res.traded = book_traded[r.slot];
    return res;
  endfunction

  function automatic directed_row_t make_row(input req_t kind, input logic [5:0] slot,
      input logic [31:0] qty, input logic [1:0] rc, input logic [2:0] rs,
      input logic [31:0] rtr, input logic [31:0] rlf, input logic typed,
      input outcome_t outcome, input lc_t lc, input logic [31:0] left,
      input logic [31:0] traded);
    directed_row_t row;
    row.req.kind = kind;
    row.req.slot = slot;
    row.req.qty = qty;
    row.req.rc = rc;
    row.req.rs = rs;
    row.req.rtr = rtr;
    row.req.rlf = rlf;
    row.typed = typed;
    row.want.outcome = outcome;
    row.want.lc = lc;
    row.want.left = left;
    row.want.traded = traded;
    return row;
  endfunction

  function automatic void queue_row(input directed_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic logic [31:0] pick_volume();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // Mostly requests that suit the slot's current lifecycle, so that orders run deep.
  function automatic order_req_t plan_request(input logic [5:0] slot);
    order_req_t r;
    r.slot = slot;
    r.qty = pick_volume();
    r.rc = 2'($urandom_range(0, 3));
    r.rs = 3'($urandom_range(0, 7));
    r.rtr = pick_volume();
    r.rlf = pick_volume();
    r.kind = req_t'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 80) begin
      if (!book_valid[slot]) begin
        r.kind = REQ_CREATE;
      end else begin
        case (book_lc[slot])
          LC_PREPARED: r.kind = ($urandom_range(0, 3) != 0) ? REQ_MARK_QUEUED : REQ_ORDER_REPORT;
          LC_QUEUED: r.kind = ($urandom_range(0, 3) != 0) ? REQ_MARK_SEND : REQ_SEND_RESULT;
          LC_SEND_PENDING: r.kind = REQ_SEND_RESULT;
          LC_SEND_UNKNOWN:
            r.kind = ($urandom_range(0, 1) != 0) ? REQ_ORDER_REPORT : REQ_TRADE_REPORT;
          LC_WORKING, LC_PART: begin
            case ($urandom_range(0, 5))
              0:       r.kind = REQ_CANCEL;
              1:       r.kind = REQ_ORDER_REPORT;
              default: r.kind = REQ_TRADE_REPORT;
            endcase
          end
          LC_CANCEL_PENDING:
            r.kind = ($urandom_range(0, 1) != 0) ? REQ_CANCEL_RESULT : REQ_ORDER_REPORT;
          default: r.kind = REQ_CREATE;
        endcase
      end
      if (r.kind == REQ_CREATE && $urandom_range(0, 3) != 0) r.qty = $urandom_range(1, 1000);
      if (r.kind == REQ_TRADE_REPORT && $urandom_range(0, 4) != 0) r.qty = $urandom_range(0, 400);
      if (r.kind == REQ_SEND_RESULT && $urandom_range(0, 2) != 0) r.rc = RC_SUCCESS;
    end
    return r;
  endfunction

  task automatic offer_request(input order_req_t r, input logic typed,
      input order_result_t typed_want);
    logic [IN_TDATA_W-1:0] word;
    order_result_t         predicted;
    word = '0;
    word[IN_SLOT_LSB +: SLOT_W] = r.slot;
    word[IN_QTY_LSB +: VOL_PORT_W] = r.qty;
    word[IN_RC_LSB +: RC_W] = r.rc;
    word[IN_RS_LSB +: RS_W] = r.rs;
    word[IN_RTR_LSB +: VOL_PORT_W] = r.rtr;
    word[IN_RLF_LSB +: VOL_PORT_W] = r.rlf;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
      in_tuser <= REQ_W'($urandom_range(0, 7));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= r.kind;
    do @(posedge clk); while (!in_tready);
    predicted = apply_to_order_book(r);
    if (typed) predicted = typed_want;
    pending_replies = {pending_replies, predicted};
    sent_count++;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
      input logic [31:0] act_val);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
    failures++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.outcome = outcome_t'(out_tdata[OUT_OUTCOME_LSB +: OUTCOME_W]);
      got.lc = lc_t'(out_tdata[OUT_LC_LSB +: LC_W]);
      got.left = out_tdata[OUT_LEFT_LSB +: VOL_PORT_W];
      got.traded = out_tdata[OUT_TRADED_LSB +: VOL_PORT_W];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %0h", $time, out_tdata);
        failures++;
      end else begin
        want = pending_replies.pop_front();
        if (got.outcome !== want.outcome) report_mismatch("outcome", want.outcome, got.outcome);
        if (got.lc !== want.lc) report_mismatch("lifecycle", want.lc, got.lc);
        if (got.left !== want.left) report_mismatch("left volume", want.left, got.left);
        if (got.traded !== want.traded) report_mismatch("traded volume", want.traded, got.traded);
        checked_count++;
        outcome_count[got.outcome]++;
        lc_seen[got.lc] = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_replies.size());
      $display("simulation failed");
      $finish;
    end
  end

  // The long hold-off lets the sender back the block up until its input stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    logic [5:0] pool [8];
    logic [5:0] slot;
    for (int i = 0; i < BOOK_SLOTS; i++) book_valid[i] = 1'b0;

    queue_row(make_row(REQ_TRADE_REPORT, 6'd5, 32'd10, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_NOT_FOUND, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_CREATE, 6'd0, 32'hFFFF_FFFF, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_SUCCESS, LC_PREPARED, 32'hFFFF_FFFF, 32'd0));
    queue_row(make_row(REQ_CREATE, 6'd63, 32'd0, 2'd3, 3'd7, '1, '1,
      1'b1, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_MARK_SEND, 6'd63, 32'd0, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_INVALID, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_MARK_QUEUED, 6'd63, 32'd0, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_SUCCESS, LC_QUEUED, 32'd0, 32'd0));
    queue_row(make_row(REQ_SEND_RESULT, 6'd63, 32'd0, 2'd3, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_SUCCESS, LC_REJECTED, 32'd0, 32'd0));
    queue_row(make_row(REQ_CANCEL, 6'd63, 32'd0, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_INVALID, LC_REJECTED, 32'd0, 32'd0));
    queue_row(make_row(REQ_CREATE, 6'd63, 32'd100, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_SUCCESS, LC_PREPARED, 32'd100, 32'd0));
    queue_row(make_row(REQ_MARK_QUEUED, 6'd63, 32'd0, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_MARK_SEND, 6'd63, 32'd0, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_SEND_RESULT, 6'd63, 32'd0, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_TRADE_REPORT, 6'd63, 32'd40, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_SUCCESS, LC_PART, 32'd60, 32'd40));
    queue_row(make_row(REQ_CANCEL_RESULT, 6'd63, 32'd0, 2'd2, 3'd0, 32'd0, 32'd0,
      1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_CANCEL, 6'd63, 32'd0, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_CANCEL_RESULT, 6'd63, 32'd0, 2'd2, 3'd0, 32'd0, 32'd0,
      1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_TRADE_REPORT, 6'd63, 32'hFFFF_FFFF, 2'd0, 3'd0, 32'd0,
      32'd0, 1'b1, OUT_SUCCESS, LC_FILLED, 32'd0, 32'hFFFF_FFFF));
    queue_row(make_row(REQ_ORDER_REPORT, 6'd0, 32'd0, 2'd0, 3'd0, 32'd7, 32'd9,
      1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_ORDER_REPORT, 6'd0, 32'd5, 2'd0, 3'd7, 32'hFFFF_FFFF,
      32'd0, 1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_ORDER_REPORT, 6'd0, 32'd8, 2'd0, RS_UNKNOWN, 32'd1,
      32'd2, 1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_ORDER_REPORT, 6'd0, 32'd0, 2'd0, RS_PART, 32'd3,
      32'hFFFF_FFFF, 1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_SEND_RESULT, 6'd0, 32'd0, RC_TIMEOUT, 3'd0, 32'd0,
      32'd0, 1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_ORDER_REPORT, 6'd0, 32'd0, 2'd0, RS_CANCELED, 32'd3,
      32'd0, 1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_CANCEL_RESULT, 6'd0, 32'd0, RC_TIMEOUT, 3'd0, 32'd0,
      32'd0, 1'b0, OUT_SUCCESS, LC_PREPARED, 32'd0, 32'd0));
    queue_row(make_row(REQ_CREATE, 6'd1, 32'd50, 2'd0, 3'd0, 32'd0, 32'd0,
      1'b1, OUT_SUCCESS, LC_PREPARED, 32'd50, 32'd0));
    queue_row(make_row(REQ_ORDER_REPORT, 6'd1, 32'd0, 2'd0, RS_FILLED, 32'd50,
      32'd0, 1'b1, OUT_INVALID, LC_PREPARED, 32'd50, 32'd0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 49; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      for (int i = 0; i < 8; i++) pool[i] = 6'($urandom_range(0, BOOK_SLOTS - 1));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 150) hold_pending = 1'b1;
        if ($urandom_range(0, 99) < 85) slot = pool[$urandom_range(0, 7)];
        else slot = 6'($urandom_range(0, BOOK_SLOTS - 1));
        offer_request(plan_request(slot), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d requests over four handshake phases and one long output hold-off;",
      sent_count);
    $display("%0d results compared: %0d success, %0d not found, %0d invalid, %0d of 10 states.",
      checked_count, outcome_count[OUT_SUCCESS], outcome_count[OUT_NOT_FOUND],
      outcome_count[OUT_INVALID], $countones(lc_seen));
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
